FILE: src/hmr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hmr_pkg
// Shared types and constants of the HTTP message receiver.
// ----------------------------------------------------------------------------
package hmr_pkg;

    localparam int LENGTH_BITS_DEF = 24;

    typedef enum logic [2:0] {
        PH_DONE = 3'd0,
        PH_REQ  = 3'd1,
        PH_HDR  = 3'd2,
        PH_BODY = 3'd3,
        PH_ERR  = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        KIND_REPLY = 2'd0,
        KIND_POST  = 2'd1,
        KIND_GET   = 2'd2,
        KIND_OTHER = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ERR_NONE   = 2'd0,
        ERR_LENGTH = 2'd1,
        ERR_EOF    = 2'd2
    } t_err;

    typedef enum logic [1:0] {
        NUM_IDLE   = 2'd0,
        NUM_SKIP   = 2'd1,
        NUM_DIGITS = 2'd2,
        NUM_STOP   = 2'd3
    } t_num;

    localparam logic [7:0] CHAR_CR    = 8'h0d;
    localparam logic [7:0] CHAR_LF    = 8'h0a;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_PLUS  = 8'h2b;
    localparam logic [7:0] CHAR_MINUS = 8'h2d;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_UP_A  = 8'h41;
    localparam logic [7:0] CHAR_UP_Z  = 8'h5a;

    localparam logic [4:0] CL_PREFIX_LEN = 5'd15;
    localparam logic [4:0] POS_MAX       = 5'd31;
    localparam logic [9:0] CODE_MAX      = 10'd999;

    // lower-case patterns; unused slots padded with zero
    localparam logic [7:0] PAT_HTTP [4] = '{"h", "t", "t", "p"};
    localparam logic [7:0] PAT_POST [4] = '{"p", "o", "s", "t"};
    localparam logic [7:0] PAT_GET  [4] = '{"g", "e", "t", 8'h00};
    localparam logic [7:0] PAT_CLEN [16] = '{
        "c", "o", "n", "t", "e", "n", "t", "-",
        "l", "e", "n", "g", "t", "h", ":", 8'h00
    };

endpackage

FILE: src/hmr_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hmr_parser
// Parse state registers and the per-byte update; presents the result of the
// item being accepted in the same cycle.
// ----------------------------------------------------------------------------
module hmr_parser #(
    parameter int LENGTH_BITS = hmr_pkg::LENGTH_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_accept,
    input  logic [7:0]             i_data_byte,
    input  logic                   i_start_of_message,
    input  logic                   i_end_of_input,
    output logic [2:0]             o_phase,
    output logic [1:0]             o_message_kind,
    output logic [9:0]             o_status_code,
    output logic [LENGTH_BITS-1:0] o_body_length,
    output logic                   o_body_valid,
    output logic [7:0]             o_body_byte,
    output logic                   o_body_last,
    output logic [1:0]             o_error_code
);
    import hmr_pkg::*;

    localparam int WIDE_BITS = LENGTH_BITS + 4;
    localparam logic [LENGTH_BITS-1:0] LEN_CAP = {LENGTH_BITS{1'b1}};

    t_phase                 r_phase,   n_phase;
    logic [4:0]             r_pos,     n_pos;
    logic [3:0]             r_flags,   n_flags;
    logic                   r_prev_cr, n_prev_cr;
    logic                   r_empty,   n_empty;
    t_kind                  r_kind,    n_kind;
    t_num                   r_num,     n_num;
    logic                   r_neg,     n_neg;
    logic [9:0]             r_code,    n_code;
    logic [LENGTH_BITS-1:0] r_len,     n_len;
    logic [LENGTH_BITS-1:0] r_remain,  n_remain;
    t_err                   r_err,     n_err;

    logic [7:0]             v_lc;
    logic [4:0]             v_pos;
    logic                   v_digit_ok;
    logic                   v_space;
    logic [3:0]             v_digit;
    logic                   v_is_len;
    logic                   v_num_go;
    logic                   v_add;
    logic [WIDE_BITS-1:0]   v_len_wide;
    logic [13:0]            v_code_wide;
    logic                   v_valid;
    logic                   v_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_REQ;
            r_pos     <= '0;
            r_flags   <= 4'hf;
            r_prev_cr <= 1'b0;
            r_empty   <= 1'b1;
            r_kind    <= KIND_OTHER;
            r_num     <= NUM_IDLE;
            r_neg     <= 1'b0;
            r_code    <= '0;
            r_len     <= '0;
            r_remain  <= '0;
            r_err     <= ERR_NONE;
        end else if (i_accept) begin
            r_phase   <= n_phase;
            r_pos     <= n_pos;
            r_flags   <= n_flags;
            r_prev_cr <= n_prev_cr;
            r_empty   <= n_empty;
            r_kind    <= n_kind;
            r_num     <= n_num;
            r_neg     <= n_neg;
            r_code    <= n_code;
            r_len     <= n_len;
            r_remain  <= n_remain;
            r_err     <= n_err;
        end
    end

    always_comb begin
        n_phase   = r_phase;
        n_pos     = r_pos;
        n_flags   = r_flags;
        n_prev_cr = r_prev_cr;
        n_empty   = r_empty;
        n_kind    = r_kind;
        n_num     = r_num;
        n_neg     = r_neg;
        n_code    = r_code;
        n_len     = r_len;
        n_remain  = r_remain;
        n_err     = r_err;
        v_valid   = 1'b0;
        v_last    = 1'b0;

        v_lc = ((i_data_byte >= CHAR_UP_A) && (i_data_byte <= CHAR_UP_Z))
             ? (i_data_byte + 8'd32) : i_data_byte;
        v_digit_ok = (i_data_byte >= CHAR_ZERO) && (i_data_byte <= CHAR_NINE);
        v_space = (i_data_byte == CHAR_SPACE)
               || ((i_data_byte >= CHAR_TAB) && (i_data_byte <= CHAR_CR));
        v_digit = 4'(i_data_byte - CHAR_ZERO);
        v_is_len = 1'b0;
        v_num_go = 1'b0;
        v_add = 1'b0;
        v_len_wide = '0;
        v_code_wide = '0;

        if (i_start_of_message) begin
            n_phase   = PH_REQ;
            n_pos     = '0;
            n_flags   = 4'hf;
            n_prev_cr = 1'b0;
            n_empty   = 1'b1;
            n_kind    = KIND_OTHER;
            n_num     = NUM_IDLE;
            n_neg     = 1'b0;
            n_code    = '0;
            n_len     = '0;
            n_remain  = '0;
            n_err     = ERR_NONE;
        end
        v_pos = n_pos;

        if (i_end_of_input) begin
            if ((n_phase == PH_REQ) || (n_phase == PH_HDR) || (n_phase == PH_BODY)) begin
                n_phase = PH_ERR;
                n_err   = ERR_EOF;
            end
        end else if (n_phase == PH_BODY) begin
            v_valid = 1'b1;
            if (n_remain != '0) begin
                n_remain = n_remain - 1'b1;
            end
            if (n_remain == '0) begin
                v_last  = 1'b1;
                n_phase = PH_DONE;
            end
        end else if ((n_phase == PH_REQ) || (n_phase == PH_HDR)) begin
            if ((i_data_byte == CHAR_LF) && n_prev_cr) begin
                // end of line
                if (n_phase == PH_REQ) begin
                    if (n_flags[0])      n_kind = KIND_REPLY;
                    else if (n_flags[1]) n_kind = KIND_POST;
                    else if (n_flags[2]) n_kind = KIND_GET;
                    else                 n_kind = KIND_OTHER;
                    n_phase = PH_HDR;
                end else if (n_empty) begin
                    if (n_neg || (n_len == '0)) begin
                        n_phase = PH_ERR;
                        n_err   = ERR_LENGTH;
                    end else begin
                        n_remain = n_len;
                        n_phase  = PH_BODY;
                    end
                end
                n_pos     = '0;
                n_flags   = 4'hf;
                n_prev_cr = 1'b0;
                n_empty   = 1'b1;
                n_num     = NUM_IDLE;
            end else begin
                if (n_phase == PH_REQ) begin
                    if (v_pos < 5'd4) begin
                        if (v_lc != PAT_HTTP[v_pos[1:0]]) n_flags[0] = 1'b0;
                        if (v_lc != PAT_POST[v_pos[1:0]]) n_flags[1] = 1'b0;
                    end
                    if ((v_pos < 5'd3) && (v_lc != PAT_GET[v_pos[1:0]])) begin
                        n_flags[2] = 1'b0;
                    end
                    if (n_num == NUM_IDLE) begin
                        if ((i_data_byte == CHAR_SPACE) && (v_pos >= 5'd4) && n_flags[0]) begin
                            n_num = NUM_SKIP;
                        end
                    end else begin
                        v_num_go = 1'b1;
                    end
                end else begin
                    v_is_len = 1'b1;
                    if (v_pos < CL_PREFIX_LEN) begin
                        if (v_lc != PAT_CLEN[v_pos[3:0]]) n_flags[3] = 1'b0;
                    end else if ((v_pos == CL_PREFIX_LEN) && n_flags[3]) begin
                        // a later length header overrides an earlier one
                        n_len = '0;
                        n_neg = 1'b0;
                        n_num = NUM_SKIP;
                    end
                    v_num_go = (n_num != NUM_IDLE);
                end

                if (v_num_go) begin
                    case (n_num)
                        NUM_SKIP: begin
                            if (v_space) begin
                                n_num = NUM_SKIP;
                            end else if (i_data_byte == CHAR_PLUS) begin
                                n_num = NUM_DIGITS;
                            end else if (i_data_byte == CHAR_MINUS) begin
                                if (v_is_len) begin
                                    n_neg = 1'b1;
                                    n_num = NUM_DIGITS;
                                end else begin
                                    n_num = NUM_STOP;
                                end
                            end else if (v_digit_ok) begin
                                v_add = 1'b1;
                                n_num = NUM_DIGITS;
                            end else begin
                                n_num = NUM_STOP;
                            end
                        end
                        NUM_DIGITS: begin
                            if (v_digit_ok) v_add = 1'b1;
                            else            n_num = NUM_STOP;
                        end
                        default: begin
                            n_num = n_num;
                        end
                    endcase
                end

                if (v_add) begin
                    if (v_is_len) begin
                        v_len_wide = (WIDE_BITS'(n_len) << 3) + (WIDE_BITS'(n_len) << 1)
                                   + WIDE_BITS'(v_digit);
                        n_len = (v_len_wide > WIDE_BITS'(LEN_CAP))
                              ? LEN_CAP : v_len_wide[LENGTH_BITS-1:0];
                    end else begin
                        v_code_wide = (14'(n_code) << 3) + (14'(n_code) << 1) + 14'(v_digit);
                        n_code = (v_code_wide > 14'(CODE_MAX)) ? CODE_MAX : v_code_wide[9:0];
                    end
                end

                if (i_data_byte == CHAR_CR) begin
                    n_empty   = (v_pos == '0);
                    n_prev_cr = 1'b1;
                end else begin
                    n_empty   = 1'b0;
                    n_prev_cr = 1'b0;
                end
                if (v_pos < POS_MAX) begin
                    n_pos = v_pos + 5'd1;
                end
            end
        end
    end

    assign o_phase        = n_phase;
    assign o_message_kind = n_kind;
    assign o_status_code  = n_code;
    assign o_body_length  = n_neg ? '0 : n_len;
    assign o_body_valid   = v_valid;
    assign o_body_byte    = v_valid ? i_data_byte : 8'h00;
    assign o_body_last    = v_last;
    assign o_error_code   = n_err;

endmodule

FILE: src/hmr_out_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hmr_out_buf
// Two-entry result register; takes a new item while the oldest one waits.
// ----------------------------------------------------------------------------
module hmr_out_buf #(
    parameter int DATA_BITS = hmr_pkg::LENGTH_BITS_DEF + 27
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  logic [DATA_BITS-1:0] i_data,
    output logic                 o_full,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [DATA_BITS-1:0] o_data
);
    logic [DATA_BITS-1:0] r_mem [2];
    logic                 r_wr_ptr;
    logic                 r_rd_ptr;
    logic [1:0]           r_count;
    logic                 v_pop;

    assign v_pop   = (r_count != 2'd0) && !i_stall;
    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) r_wr_ptr <= ~r_wr_ptr;
            if (v_pop)  r_rd_ptr <= ~r_rd_ptr;
            case ({i_push, v_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

FILE: src/http_message_receiver_unit.sv
`timescale 1ns / 1ps
// Each accepted item's result is registered before it is offered.
// Throughput: one byte per cycle while the input is not stalled; the parse
// state is updated by one pass of logic per byte and results go through
// a two-entry output register. Input stall rises only when both output
// entries hold untaken results. Reset (synchronous, active low) puts the
// parser in the request line phase and empties the output register.
// ----------------------------------------------------------------------------
// http_message_receiver_unit
// Byte-serial HTTP message parser with body pass-through.
// ----------------------------------------------------------------------------
module http_message_receiver_unit #(
    parameter int LENGTH_BITS = hmr_pkg::LENGTH_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [7:0]             i_data_byte,
    input  logic                   i_start_of_message,
    input  logic                   i_end_of_input,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [2:0]             o_phase,
    output logic [1:0]             o_message_kind,
    output logic [9:0]             o_status_code,
    output logic [LENGTH_BITS-1:0] o_body_length,
    output logic                   o_body_valid,
    output logic [7:0]             o_body_byte,
    output logic                   o_body_last,
    output logic [1:0]             o_error_code
);
    import hmr_pkg::*;

    localparam int DATA_BITS = LENGTH_BITS + 27;

    logic                   w_accept;
    logic                   w_full;
    logic [2:0]             w_phase;
    logic [1:0]             w_kind;
    logic [9:0]             w_code;
    logic [LENGTH_BITS-1:0] w_len;
    logic                   w_bvalid;
    logic [7:0]             w_byte;
    logic                   w_last;
    logic [1:0]             w_err;
    logic [DATA_BITS-1:0]   w_push_data;
    logic [DATA_BITS-1:0]   w_out_data;

    assign o_in_stall = w_full;
    assign w_accept   = i_in_valid && !w_full;

    hmr_parser #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_parser (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_accept           (w_accept),
        .i_data_byte        (i_data_byte),
        .i_start_of_message (i_start_of_message),
        .i_end_of_input     (i_end_of_input),
        .o_phase            (w_phase),
        .o_message_kind     (w_kind),
        .o_status_code      (w_code),
        .o_body_length      (w_len),
        .o_body_valid       (w_bvalid),
        .o_body_byte        (w_byte),
        .o_body_last        (w_last),
        .o_error_code       (w_err)
    );

    assign w_push_data = {w_phase, w_kind, w_code, w_len, w_bvalid, w_byte, w_last, w_err};

    hmr_out_buf #(
        .DATA_BITS (DATA_BITS)
    ) u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_accept),
        .i_data  (w_push_data),
        .o_full  (w_full),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (w_out_data)
    );

    assign {o_phase, o_message_kind, o_status_code, o_body_length,
            o_body_valid, o_body_byte, o_body_last, o_error_code} = w_out_data;

endmodule
